@@ sv/mpbm_pkg.sv @@
// Shared types and constants of the multi-pattern byte matcher.
package mpbm_pkg;

    localparam int BYTE_W       = 8;
    localparam int PATTERN_REGS = 4;
    localparam int LEN_W        = 3;
    localparam int PATTERN_W    = 64;
    localparam int POS_W        = 16;
    localparam int IDX_W        = 2;
    localparam int COUNT_W      = 3;
    localparam int LENGTHS_W    = PATTERN_REGS * LEN_W;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 64;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_COUNT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTHS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_ZERO    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_ONE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_TWO     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_THREE   = 3'd5;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              buffer_start;
    } t_in_item;

    typedef struct packed {
        logic             match_found;
        logic [IDX_W-1:0] pattern_index;
        logic [POS_W-1:0] match_start;
    } t_out_item;

    // Control shared by every history cell
    typedef struct packed {
        logic shift;   // transaction accepted: advance the chain
        logic clear;   // this byte opens a new buffer
    } t_cell_ctrl;

    typedef logic [PATTERN_REGS-1:0][PATTERN_W-1:0] t_pattern_set;
    typedef logic [PATTERN_REGS-1:0][LEN_W-1:0]     t_len_set;

endpackage

@@ sv/multi_pattern_byte_matcher_unit.sv @@
// Top level of the multi-pattern byte matcher: config registers, cell chain, output stage.
//
//  channel   | direction | handshake                  | payload
//  ----------+-----------+----------------------------+-----------------------
//  in        | input     | i_in_valid / o_in_ready    | i_in_item  (t_in_item)
//  out       | output    | o_out_valid / i_out_ready  | o_out_item (t_out_item)
//  cfg       | input     | i_cfg_we (no wait)         | i_cfg_index, i_cfg_data
//
//  One byte per cycle while the output register is empty or drained: a byte is compared in
//  the cycle it is accepted and its result lands in the output register on the next edge.
//  The compare path (byte select, 8-bit compare, AND over the cell chain,
//  priority pick, 16-bit subtract) sets the cycle time.
//  The input stays ready while the output register is empty or being drained.
//  Reset (synchronous, active low) empties history and position and restores
//  the register defaults: one pattern of one zero byte.
module multi_pattern_byte_matcher_unit #(
    parameter int MAX_PATTERNS      = 4,
    parameter int MAX_PATTERN_BYTES = 8,
    parameter int BUFFER_BYTES      = 65536
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  mpbm_pkg::t_in_item                i_in_item,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output mpbm_pkg::t_out_item               o_out_item,
    input  logic                              i_cfg_we,
    input  logic [mpbm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mpbm_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import mpbm_pkg::*;

    // History depth: bytes before the current one that a longest pattern needs
    localparam int HIST_DEPTH = MAX_PATTERN_BYTES - 1;
    localparam logic [LEN_W-1:0] LEN_M1_MAX = LEN_W'(MAX_PATTERN_BYTES - 1);
    localparam logic [POS_W-1:0] LAST_POS   = POS_W'(BUFFER_BYTES - 1);

    // Configuration registers
    logic [COUNT_W-1:0]   r_pattern_count;
    logic [LENGTHS_W-1:0] r_pattern_lengths;
    t_pattern_set         r_patterns;

    // Stream state
    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_past_end, n_past_end;

    // Output stage
    t_out_item r_out, n_out;
    logic      r_out_valid;

    logic       accept;
    t_cell_ctrl cell_ctrl;
    t_len_set   len_m1;
    logic [PATTERN_REGS-1:0] active;
    logic [PATTERN_REGS-1:0] hit;

    logic [HIST_DEPTH:0][BYTE_W-1:0]        chain_byte;
    logic [HIST_DEPTH:0]                    chain_valid;
    logic [HIST_DEPTH-1:0][PATTERN_REGS-1:0] cell_hit;

    assign o_in_ready  = ~r_out_valid | i_out_ready;
    assign accept      = i_in_valid & o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign cell_ctrl.shift = accept;
    assign cell_ctrl.clear = i_in_item.buffer_start;

    // Configuration writes; indexes beyond the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_count   <= COUNT_W'(1);
            r_pattern_lengths <= '0;
            r_patterns        <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_PATTERN_COUNT:   r_pattern_count   <= i_cfg_data[COUNT_W-1:0];
                REG_PATTERN_LENGTHS: r_pattern_lengths <= i_cfg_data[LENGTHS_W-1:0];
                REG_PATTERN_ZERO:    r_patterns[0]     <= i_cfg_data;
                REG_PATTERN_ONE:     r_patterns[1]     <= i_cfg_data;
                REG_PATTERN_TWO:     r_patterns[2]     <= i_cfg_data;
                REG_PATTERN_THREE:   r_patterns[3]     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp each length to the supported maximum and mark active patterns
    always_comb begin
        logic [LEN_W-1:0] raw;
        for (int p = 0; p < PATTERN_REGS; p++) begin
            raw       = r_pattern_lengths[p*LEN_W +: LEN_W];
            len_m1[p] = (raw > LEN_M1_MAX) ? LEN_M1_MAX : raw;
            active[p] = (COUNT_W'(p) < r_pattern_count) && (p < MAX_PATTERNS);
        end
    end

    // The current byte enters the chain head; the head input is always valid
    assign chain_byte[0]  = i_in_item.data_byte;
    assign chain_valid[0] = 1'b1;

    for (genvar c = 0; c < HIST_DEPTH; c++) begin : g_cell
        mpbm_cell #(
            .AGE (c + 1)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctrl     (cell_ctrl),
            .i_byte     (chain_byte[c]),
            .i_valid    (chain_valid[c]),
            .i_patterns (r_patterns),
            .i_len_m1   (len_m1),
            .o_byte     (chain_byte[c+1]),
            .o_valid    (chain_valid[c+1]),
            .o_hit      (cell_hit[c])
        );
    end

    // A pattern hits when its last byte equals the current byte and every cell agrees
    always_comb begin
        logic all_cells;
        for (int p = 0; p < PATTERN_REGS; p++) begin
            all_cells = 1'b1;
            for (int c = 0; c < HIST_DEPTH; c++) begin
                all_cells = all_cells & cell_hit[c][p];
            end
            hit[p] = active[p] && all_cells &&
                     (i_in_item.data_byte == r_patterns[p][{len_m1[p], 3'b000} +: BYTE_W]);
        end
    end

    // Position and end flag after a new buffer clears them
    always_comb begin
        logic [POS_W-1:0] pos;
        logic             past_end;
        pos      = i_in_item.buffer_start ? '0   : r_pos;
        past_end = i_in_item.buffer_start ? 1'b0 : r_past_end;

        if (pos == LAST_POS) begin
            n_pos      = pos;
            n_past_end = 1'b1;
        end else begin
            n_pos      = POS_W'(pos + POS_W'(1));
            n_past_end = past_end;
        end

        // Lowest-numbered hit wins
        n_out = '0;
        if (!past_end) begin
            for (int p = PATTERN_REGS - 1; p >= 0; p--) begin
                if (hit[p]) begin
                    n_out.match_found   = 1'b1;
                    n_out.pattern_index = IDX_W'(p);
                    n_out.match_start   = POS_W'(pos - POS_W'(len_m1[p]));
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_past_end  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_pos      <= n_pos;
                r_past_end <= n_past_end;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the result until the transaction completes
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

endmodule

@@ sv/mpbm_cell.sv @@
// One history cell: holds the byte of a fixed age and compares it to every pattern.
module mpbm_cell #(
    parameter int AGE = 1
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  mpbm_pkg::t_cell_ctrl      i_ctrl,
    input  logic [mpbm_pkg::BYTE_W-1:0] i_byte,
    input  logic                      i_valid,
    input  mpbm_pkg::t_pattern_set    i_patterns,
    input  mpbm_pkg::t_len_set        i_len_m1,
    output logic [mpbm_pkg::BYTE_W-1:0] o_byte,
    output logic                      o_valid,
    output logic [mpbm_pkg::PATTERN_REGS-1:0] o_hit
);
    import mpbm_pkg::*;

    localparam logic [LEN_W-1:0] AGE_L = LEN_W'(AGE);

    logic [BYTE_W-1:0] r_byte;
    logic              r_valid;
    logic              eff_valid;

    assign eff_valid = r_valid & ~i_ctrl.clear;
    assign o_byte    = r_byte;
    assign o_valid   = eff_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.shift) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_byte <= i_byte;
        end
    end

    // Byte of age AGE must equal pattern byte (len-1-AGE); older than the pattern is don't-care
    always_comb begin
        logic [LEN_W-1:0] sel;
        for (int p = 0; p < PATTERN_REGS; p++) begin
            sel = LEN_W'(i_len_m1[p] - AGE_L);
            if (AGE_L > i_len_m1[p]) begin
                o_hit[p] = 1'b1;
            end else begin
                o_hit[p] = eff_valid &&
                           (r_byte == i_patterns[p][{sel, 3'b000} +: BYTE_W]);
            end
        end
    end

endmodule

@@ sv/mpbm_checker.sv @@
// Port-level checker of the multi-pattern byte matcher and its bind.
module mpbm_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_ready,
    input logic                              o_out_valid,
    input logic                              i_out_ready,
    input mpbm_pkg::t_out_item               o_out_item
);
    import mpbm_pkg::*;

    // Every accepted byte yields a result on the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> o_out_valid)
        else $error("accepted byte produced no result");

    // An empty output stage never blocks the input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output stage");

    // A miss carries zero index and zero start
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.match_found) |->
        (o_out_item.pattern_index == '0 && o_out_item.match_start == '0))
        else $error("miss with nonzero index or start");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_item)))
        else $error("stalled result changed");

endmodule

bind multi_pattern_byte_matcher_unit mpbm_checker u_mpbm_checker (.*);
